### hdl/assert_macros.svh
// assertion macros for the rotary knob decoder, used by the rkd_decode module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define RKD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rkd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkd assertion failed");

`else

`define RKD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RKD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/rkd_pkg.sv
// shared types and constants for the rotary knob decoder
`timescale 1ns / 1ps

package rkd_pkg;

    // width of the adjusted value and its modular arithmetic
    localparam int VALUE_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // motion codes that mark a complete detent
    localparam logic [7:0] MOTION_UP   = 8'h24;
    localparam logic [7:0] MOTION_DOWN = 8'h42;

    // the press threshold saturates here so the counter never wraps
    localparam logic [CFG_WIDTH-1:0] THR_MAX = 16'hFFFE;

    // register indexes on the configuration port
    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_UPPER = 2'd1;
    localparam logic [1:0] REG_LOWER = 2'd2;
    localparam logic [1:0] REG_LONG  = 2'd3;

    // reset values of the registers
    localparam logic [CFG_WIDTH-1:0] RST_STEP  = 16'd1;
    localparam logic [CFG_WIDTH-1:0] RST_UPPER = 16'hFFFF;
    localparam logic [CFG_WIDTH-1:0] RST_LOWER = 16'd0;
    localparam logic [CFG_WIDTH-1:0] RST_LONG  = 16'd1024;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_UP    = 3'd1,
        EV_DOWN  = 3'd2,
        EV_SHORT = 3'd3,
        EV_LONG  = 3'd4
    } rkd_event_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] step_size;
        logic [CFG_WIDTH-1:0] upper_limit;
        logic [CFG_WIDTH-1:0] lower_limit;
        logic [CFG_WIDTH-1:0] long_press_ticks;
    } rkd_cfg_t;

endpackage

### hdl/rkd_cfg_regs.sv
// configuration register file behind the apb port
`timescale 1ns / 1ps

module rkd_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rkd_pkg::APB_AW-1:0]  paddr,
    input  logic [rkd_pkg::APB_DW-1:0]  pwdata,
    output logic [rkd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output rkd_pkg::rkd_cfg_t           cfg
);

    rkd_pkg::rkd_cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size        <= rkd_pkg::RST_STEP;
            cfg_reg.upper_limit      <= rkd_pkg::RST_UPPER;
            cfg_reg.lower_limit      <= rkd_pkg::RST_LOWER;
            cfg_reg.long_press_ticks <= rkd_pkg::RST_LONG;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rkd_pkg::REG_STEP:  cfg_reg.step_size        <= pwdata[15:0];
                rkd_pkg::REG_UPPER: cfg_reg.upper_limit      <= pwdata[15:0];
                rkd_pkg::REG_LOWER: cfg_reg.lower_limit      <= pwdata[15:0];
                rkd_pkg::REG_LONG:  cfg_reg.long_press_ticks <= pwdata[15:0];
                default:            cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            rkd_pkg::REG_STEP:  prdata = {16'd0, cfg_reg.step_size};
            rkd_pkg::REG_UPPER: prdata = {16'd0, cfg_reg.upper_limit};
            rkd_pkg::REG_LOWER: prdata = {16'd0, cfg_reg.lower_limit};
            rkd_pkg::REG_LONG:  prdata = {16'd0, cfg_reg.long_press_ticks};
            default:            prdata = '0;
        endcase
    end

endmodule

### hdl/rkd_decode.sv
// encoder and button state tracking with per-tick event decode
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rkd_decode
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           line_a,
    input  logic                           line_b,
    input  logic                           button_level,
    input  logic [rkd_pkg::CFG_WIDTH-1:0]  long_press_ticks,
    output rkd_pkg::rkd_event_t            event_code
);

    logic                          released_reg, released_next;
    logic [rkd_pkg::CFG_WIDTH-1:0] press_cnt_reg, press_cnt_next;
    logic [7:0]                    motion_reg, motion_next;
    logic                          saved_a_reg, saved_a_next;
    logic                          saved_b_reg, saved_b_next;
    logic                          moving_reg, moving_next;
    logic [rkd_pkg::CFG_WIDTH-1:0] thr;
    logic                          long_ev;
    logic                          short_ev;
    rkd_pkg::rkd_event_t           detent_ev;
    logic                          cancel;

    // saturated press threshold
    assign thr = (long_press_ticks > rkd_pkg::THR_MAX) ? rkd_pkg::THR_MAX : long_press_ticks;

    // button press counter
    always_comb
    begin
        released_next  = released_reg;
        press_cnt_next = press_cnt_reg;
        long_ev        = 1'b0;
        short_ev       = 1'b0;
        if (!button_level)
        begin
            released_next = 1'b0;
            if (press_cnt_reg < thr)
            begin
                press_cnt_next = press_cnt_reg + 16'd1;
            end
            else if (press_cnt_reg == thr)
            begin
                press_cnt_next = press_cnt_reg + 16'd1;
                long_ev        = 1'b1;
            end
        end
        else
        begin
            short_ev       = !released_reg && (press_cnt_reg < thr);
            press_cnt_next = '0;
            released_next  = 1'b1;
        end
    end

    // quadrature motion tracking
    always_comb
    begin
        motion_next  = motion_reg;
        saved_a_next = saved_a_reg;
        saved_b_next = saved_b_reg;
        moving_next  = moving_reg;
        detent_ev    = rkd_pkg::EV_NONE;
        cancel       = 1'b0;
        if (line_a && line_b)
        begin
            if (moving_reg)
            begin
                moving_next = 1'b0;
                cancel      = 1'b1;
                if (motion_reg == rkd_pkg::MOTION_DOWN)
                begin
                    detent_ev = rkd_pkg::EV_DOWN;
                end
                else if (motion_reg == rkd_pkg::MOTION_UP)
                begin
                    detent_ev = rkd_pkg::EV_UP;
                end
            end
            motion_next  = '0;
            saved_a_next = 1'b1;
            saved_b_next = 1'b1;
        end
        else
        begin
            moving_next = 1'b1;
            if ((line_a != saved_a_reg) || (line_b != saved_b_reg))
            begin
                saved_a_next = line_a;
                saved_b_next = line_b;
                // two shifts of a and b; the code stays even so no carry
                motion_next  = {motion_reg[5:1], line_a, line_b, 1'b0};
            end
        end
    end

    // event priority: short, then long, else detent; a return to rest after motion cancels both button events
    always_comb
    begin
        priority if (short_ev && !cancel)
        begin
            event_code = rkd_pkg::EV_SHORT;
        end
        else if (long_ev && !cancel)
        begin
            event_code = rkd_pkg::EV_LONG;
        end
        else
        begin
            event_code = detent_ev;
        end
    end

    // state registers, updated once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            released_reg  <= 1'b1;
            press_cnt_reg <= '0;
            motion_reg    <= '0;
            saved_a_reg   <= 1'b1;
            saved_b_reg   <= 1'b1;
            moving_reg    <= 1'b0;
        end
        else if (fire)
        begin
            released_reg  <= released_next;
            press_cnt_reg <= press_cnt_next;
            motion_reg    <= motion_next;
            saved_a_reg   <= saved_a_next;
            saved_b_reg   <= saved_b_next;
            moving_reg    <= moving_next;
        end
    end

    // consistency of the tracked state
    `RKD_ASSERT_IMP(a_released_clear, clk, rst_n, released_reg, press_cnt_reg == '0)
    `RKD_ASSERT_IMP(a_idle_code, clk, rst_n, !moving_reg, motion_reg == '0)
    `RKD_ASSERT_IMP(a_idle_lines, clk, rst_n, !moving_reg, saved_a_reg && saved_b_reg)

endmodule

### hdl/rkd_adjust.sv
// value stepping with wrap between the limits
`timescale 1ns / 1ps

module rkd_adjust
(
    input  rkd_pkg::rkd_event_t              event_code,
    input  logic [rkd_pkg::VALUE_WIDTH-1:0]  current_value,
    input  rkd_pkg::rkd_cfg_t                cfg,
    output logic [rkd_pkg::VALUE_WIDTH-1:0]  new_value
);

    logic [rkd_pkg::VALUE_WIDTH-1:0] step;
    logic [rkd_pkg::VALUE_WIDTH-1:0] upper;
    logic [rkd_pkg::VALUE_WIDTH-1:0] lower;

    assign step  = rkd_pkg::VALUE_WIDTH'(cfg.step_size);
    assign upper = rkd_pkg::VALUE_WIDTH'(cfg.upper_limit);
    assign lower = rkd_pkg::VALUE_WIDTH'(cfg.lower_limit);

    // step up or down, wrapping to the opposite limit
    always_comb
    begin
        unique case (event_code)
            rkd_pkg::EV_UP:
            begin
                new_value = (current_value < upper) ? (current_value + step) : lower;
            end
            rkd_pkg::EV_DOWN:
            begin
                new_value = (current_value > lower) ? (current_value - step) : upper;
            end
            default:
            begin
                new_value = current_value;
            end
        endcase
    end

endmodule

### hdl/rotary_knob_decoder_adjuster.sv
// Rotary knob decoder with button and value adjuster, top level.
// An accepted input beat passes the input register, then decode and step into
// the result register. Throughput: one beat per cycle while out_stall is low;
// the whole tick update is one pass of logic.
// Reset: rst_n clears both pipeline stages, the knob state and loads
// register defaults; no clearing pass, beats are taken right after reset.
`timescale 1ns / 1ps

module rotary_knob_decoder_adjuster
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rkd_pkg::APB_AW-1:0]     paddr,
    input  logic [rkd_pkg::APB_DW-1:0]     pwdata,
    output logic [rkd_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           line_a,
    input  logic                           line_b,
    input  logic                           button_level,
    input  logic [rkd_pkg::VALUE_WIDTH-1:0] current_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     event_code,
    output logic [rkd_pkg::VALUE_WIDTH-1:0] new_value
);

    rkd_pkg::rkd_cfg_t               cfg;
    logic                            s1_valid_reg;
    logic                            s1_a_reg;
    logic                            s1_b_reg;
    logic                            s1_btn_reg;
    logic [rkd_pkg::VALUE_WIDTH-1:0] s1_value_reg;
    logic                            out_valid_reg;
    logic [2:0]                      out_event_reg;
    logic [rkd_pkg::VALUE_WIDTH-1:0] out_value_reg;
    logic                            out_free;
    logic                            s1_fire;
    logic                            in_fire;
    rkd_pkg::rkd_event_t             dec_event;
    logic [rkd_pkg::VALUE_WIDTH-1:0] adj_value;

    rkd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline flow control
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_a_reg     <= line_a;
            s1_b_reg     <= line_b;
            s1_btn_reg   <= button_level;
            s1_value_reg <= current_value;
        end
    end

    rkd_decode u_decode
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (s1_fire),
        .line_a           (s1_a_reg),
        .line_b           (s1_b_reg),
        .button_level     (s1_btn_reg),
        .long_press_ticks (cfg.long_press_ticks),
        .event_code       (dec_event)
    );

    rkd_adjust u_adjust
    (
        .event_code    (dec_event),
        .current_value (s1_value_reg),
        .cfg           (cfg),
        .new_value     (adj_value)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_event_reg <= dec_event;
            out_value_reg <= adj_value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_event_reg;
    assign new_value  = out_value_reg;

endmodule

### tb/rotary_knob_decoder_adjuster_tb.sv
// self-checking testbench for the rotary knob decoder and value adjuster
`timescale 1ns / 1ps

module rotary_knob_decoder_adjuster_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        rkd_pkg::rkd_event_t                 ev;
        logic [rkd_pkg::VALUE_WIDTH-1:0]     val;
    } knob_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [rkd_pkg::APB_AW-1:0]          paddr;
    logic [rkd_pkg::APB_DW-1:0]          pwdata;
    logic [rkd_pkg::APB_DW-1:0]          prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_stall;
    logic                                line_a;
    logic                                line_b;
    logic                                button_level;
    logic [rkd_pkg::VALUE_WIDTH-1:0]     current_value;
    logic                                out_valid;
    logic                                out_stall;
    logic [2:0]                          event_code;
    logic [rkd_pkg::VALUE_WIDTH-1:0]     new_value;

    // shadow of the register file and the knob state
    rkd_pkg::rkd_cfg_t                   knob_cfg;
    logic                                btn_up;
    logic [rkd_pkg::CFG_WIDTH-1:0]       press_cnt;
    logic [7:0]                          quad_code;
    logic                                last_a;
    logic                                last_b;
    logic                                in_motion;

    knob_result_t               pending_results[$];
    knob_result_t               want_r;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int fail_count = 0;
    int tick_count = 0;
    int result_count = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;
    int ev_seen[5] = '{0, 0, 0, 0, 0};

    // random button run state
    logic btn_lvl = 1'b1;
    int   btn_left = 0;

    rotary_knob_decoder_adjuster u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line_a        (line_a),
        .line_b        (line_b),
        .button_level  (button_level),
        .current_value (current_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_code    (event_code),
        .new_value     (new_value)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
        begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    // one sample tick of the knob: button counter, quadrature code, value step
    function automatic void knob_tick(input logic a, input logic b, input logic btn,
                                      input logic [rkd_pkg::VALUE_WIDTH-1:0] cur,
                                      output rkd_pkg::rkd_event_t ev,
                                      output logic [rkd_pkg::VALUE_WIDTH-1:0] nv);
        logic [rkd_pkg::CFG_WIDTH-1:0] thr;
        logic                          long_hit;
        logic                          short_hit;
        thr = (knob_cfg.long_press_ticks > rkd_pkg::THR_MAX) ? rkd_pkg::THR_MAX
                                                              : knob_cfg.long_press_ticks;
        long_hit = 1'b0;
        short_hit = 1'b0;
        ev = rkd_pkg::EV_NONE;
        nv = cur;

        // button hold counter
        if (!btn)
        begin
            btn_up = 1'b0;
            if (press_cnt < thr)
            begin
                press_cnt = press_cnt + 1'b1;
            end
            else if (press_cnt == thr)
            begin
                press_cnt = press_cnt + 1'b1;
                long_hit = 1'b1;
            end
        end
        else
        begin
            if (!btn_up && press_cnt < thr)
            begin
                short_hit = 1'b1;
            end
            press_cnt = '0;
            btn_up = 1'b1;
        end

        // quadrature decode, detent when both lines come back high
        if (a && b)
        begin
            if (in_motion)
            begin
                in_motion = 1'b0;
                if (quad_code == rkd_pkg::MOTION_DOWN)
                begin
                    ev = rkd_pkg::EV_DOWN;
                end
                else if (quad_code == rkd_pkg::MOTION_UP)
                begin
                    ev = rkd_pkg::EV_UP;
                end
                long_hit = 1'b0;
                short_hit = 1'b0;
            end
            quad_code = '0;
            last_a = 1'b1;
            last_b = 1'b1;
        end
        else
        begin
            in_motion = 1'b1;
            if (a != last_a || b != last_b)
            begin
                last_a = a;
                last_b = b;
                quad_code = (quad_code + a) << 1;
                quad_code = (quad_code + b) << 1;
            end
        end

        if (long_hit)
        begin
            ev = rkd_pkg::EV_LONG;
        end
        if (short_hit)
        begin
            ev = rkd_pkg::EV_SHORT;
        end

        // value step with wrap between the limits
        if (ev == rkd_pkg::EV_UP)
        begin
            nv = (cur < knob_cfg.upper_limit) ? cur + knob_cfg.step_size
                                              : knob_cfg.lower_limit;
        end
        else if (ev == rkd_pkg::EV_DOWN)
        begin
            nv = (cur > knob_cfg.lower_limit) ? cur - knob_cfg.step_size
                                              : knob_cfg.upper_limit;
        end
    endfunction

    // drive one input beat, hold it until taken, then log its expected result
    task automatic send_tick(input logic a, input logic b, input logic btn,
                             input logic [rkd_pkg::VALUE_WIDTH-1:0] val);
        knob_result_t                    r;
        rkd_pkg::rkd_event_t             e;
        logic [rkd_pkg::VALUE_WIDTH-1:0] nv;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        line_a        <= a;
        line_b        <= b;
        button_level  <= btn;
        current_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        knob_tick(a, b, btn, val, e, nv);
        r.ev = e;
        r.val = nv;
        pending_results.push_back(r);
        tick_count++;
    endtask

    // drop valid and let every pending result drain out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    // apb read of one register, compared with the expected value
    task automatic read_check(input logic [1:0] idx,
                              input logic [rkd_pkg::CFG_WIDTH-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[rkd_pkg::CFG_WIDTH-1:0] !== v)
        begin
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      idx, prdata[rkd_pkg::CFG_WIDTH-1:0], v));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // apb write of one register followed by a read back
    task automatic write_reg(input logic [1:0] idx,
                             input logic [rkd_pkg::CFG_WIDTH-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(rkd_pkg::APB_DW-rkd_pkg::CFG_WIDTH){1'b0}}, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            rkd_pkg::REG_STEP:  knob_cfg.step_size = v;
            rkd_pkg::REG_UPPER: knob_cfg.upper_limit = v;
            rkd_pkg::REG_LOWER: knob_cfg.lower_limit = v;
            rkd_pkg::REG_LONG:  knob_cfg.long_press_ticks = v;
            default: ;
        endcase
        cfg_writes++;
        read_check(idx, v);
    endtask

    task automatic apply_config(input rkd_pkg::rkd_cfg_t c);
        wait_idle();
        write_reg(rkd_pkg::REG_STEP, c.step_size);
        write_reg(rkd_pkg::REG_UPPER, c.upper_limit);
        write_reg(rkd_pkg::REG_LOWER, c.lower_limit);
        write_reg(rkd_pkg::REG_LONG, c.long_press_ticks);
    endtask

    // random tick: button runs and values near the limits or random
    task automatic random_tick(input logic a, input logic b);
        int                              thr_cap;
        logic [rkd_pkg::VALUE_WIDTH-1:0] v;
        thr_cap = (knob_cfg.long_press_ticks > 30) ? 30 : knob_cfg.long_press_ticks;
        if (btn_left == 0)
        begin
            btn_lvl = ~btn_lvl;
            btn_left = btn_lvl ? $urandom_range(1, 10) : $urandom_range(1, thr_cap + 3);
        end
        btn_left--;
        case ($urandom_range(0, 7))
            0: v = knob_cfg.upper_limit;
            1: v = knob_cfg.lower_limit;
            2: v = knob_cfg.upper_limit - 1'b1;
            3: v = knob_cfg.lower_limit + 1'b1;
            4: v = knob_cfg.upper_limit + 1'b1;
            5: v = knob_cfg.lower_limit - 1'b1;
            default: v = rkd_pkg::VALUE_WIDTH'($urandom);
        endcase
        send_tick(a, b, btn_lvl, v);
    endtask

    // mostly clean detent sequences, some bounces and line noise
    task automatic run_random(input int n_ticks);
        int   start;
        int   kind;
        logic dir_up;
        start = tick_count;
        while (tick_count - start < n_ticks)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                dir_up = 1'($urandom_range(0, 1));
                for (int s = 0; s < 3; s++)
                begin
                    if (dir_up)
                    begin
                        repeat ($urandom_range(1, 3)) random_tick(s == 2, s == 0);
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 3)) random_tick(s == 0, s == 2);
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        break;
                    end
                end
                random_tick(1'b1, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    random_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(0, 3)) random_tick(1'b1, 1'b1);
        end
    endtask

    task automatic test_register_access();
        read_check(rkd_pkg::REG_STEP, rkd_pkg::RST_STEP);
        read_check(rkd_pkg::REG_UPPER, rkd_pkg::RST_UPPER);
        read_check(rkd_pkg::REG_LOWER, rkd_pkg::RST_LOWER);
        read_check(rkd_pkg::REG_LONG, rkd_pkg::RST_LONG);
    endtask

    // detents in both directions, wrap at both limits, unknown code
    task automatic test_detent_events();
        send_tick(1'b0, 1'b1, 1'b1, 16'h0000);
        send_tick(1'b0, 1'b0, 1'b1, 16'h0000);
        send_tick(1'b1, 1'b0, 1'b1, 16'h0000);
        send_tick(1'b1, 1'b1, 1'b1, 16'h0000);
        send_tick(1'b1, 1'b0, 1'b1, 16'h0000);
        send_tick(1'b0, 1'b0, 1'b1, 16'h0000);
        send_tick(1'b0, 1'b1, 1'b1, 16'h0000);
        send_tick(1'b1, 1'b1, 1'b1, 16'h0000);
        send_tick(1'b0, 1'b1, 1'b1, 16'hFFFF);
        send_tick(1'b0, 1'b0, 1'b1, 16'hFFFF);
        send_tick(1'b1, 1'b0, 1'b1, 16'hFFFF);
        send_tick(1'b1, 1'b1, 1'b1, 16'hFFFF);
        // bounce: back high with an unknown code
        send_tick(1'b0, 1'b1, 1'b1, 16'h5A5A);
        send_tick(1'b1, 1'b1, 1'b1, 16'hA5A5);
    endtask

    // long press, short press, long press held through a detent, zero threshold
    task automatic test_button_events();
        wait_idle();
        write_reg(rkd_pkg::REG_LONG, 16'd2);
        send_tick(1'b1, 1'b1, 1'b0, 16'h1234);
        send_tick(1'b1, 1'b1, 1'b0, 16'h1234);
        send_tick(1'b1, 1'b1, 1'b0, 16'h1234);
        send_tick(1'b1, 1'b1, 1'b1, 16'h1234);
        send_tick(1'b1, 1'b1, 1'b0, 16'h0042);
        send_tick(1'b1, 1'b1, 1'b1, 16'h0042);
        send_tick(1'b0, 1'b1, 1'b0, 16'h0100);
        send_tick(1'b0, 1'b0, 1'b0, 16'h0100);
        send_tick(1'b1, 1'b0, 1'b0, 16'h0100);
        send_tick(1'b1, 1'b1, 1'b1, 16'h0100);
        wait_idle();
        write_reg(rkd_pkg::REG_LONG, 16'd0);
        send_tick(1'b1, 1'b1, 1'b0, 16'h7FFF);
        send_tick(1'b1, 1'b1, 1'b0, 16'h7FFF);
        send_tick(1'b1, 1'b1, 1'b1, 16'h7FFF);
    endtask

    // saturated threshold: a hold well below it still ends as a short press
    task automatic test_threshold_max();
        apply_config({16'd1, 16'hFFFF, 16'd0, 16'hFFFF});
        repeat (60) send_tick(1'b1, 1'b1, 1'b0, rkd_pkg::VALUE_WIDTH'($urandom));
        send_tick(1'b1, 1'b1, 1'b1, rkd_pkg::VALUE_WIDTH'($urandom));
    endtask

    // random traffic over several register settings and idling patterns
    task automatic test_random_phases();
        rkd_pkg::rkd_cfg_t settings[6];
        settings[0] = {16'd1,    16'hFFFF, 16'd0,    16'd5};
        settings[1] = {16'hFFFF, 16'hFFFF, 16'd0,    16'd1};
        settings[2] = {16'd0,    16'd0,    16'd0,    16'd2};
        settings[3] = {16'h1234, 16'h0010, 16'hFFF0, 16'd0};
        settings[4] = {16'd300,  16'hFFFF, 16'hFFFF, 16'd20};
        settings[5] = {16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom_range(1, 30))};
        for (int p = 0; p < 6; p++)
        begin
            apply_config(settings[p]);
            if (p < 2)
            begin
                src_idle_pct = 36;
                snk_stall_pct = 56;
            end
            else if (p < 4)
            begin
                src_idle_pct = 56;
                snk_stall_pct = 36;
            end
            else
            begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            run_random(330);
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result beat with no tick pending");
            end
            else
            begin
                want_r = pending_results.pop_front();
                ev_seen[want_r.ev]++;
                if (event_code !== want_r.ev)
                begin
                    report_mismatch($sformatf("event_code %0d, expected %0d",
                                              event_code, want_r.ev));
                end
                if (new_value !== want_r.val)
                begin
                    report_mismatch($sformatf("new_value %h, expected %h",
                                              new_value, want_r.val));
                end
            end
        end
    end

    // watchdog on cycles without any beat or register access
    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        line_a = 1'b1;
        line_b = 1'b1;
        button_level = 1'b1;
        current_value = '0;
        out_stall = 1'b0;
        knob_cfg = {rkd_pkg::RST_STEP, rkd_pkg::RST_UPPER, rkd_pkg::RST_LOWER,
                    rkd_pkg::RST_LONG};
        btn_up = 1'b1;
        press_cnt = '0;
        quad_code = '0;
        last_a = 1'b1;
        last_b = 1'b1;
        in_motion = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_detent_events();
        test_button_events();
        test_random_phases();
        test_threshold_max();

        wait_idle();
        repeat (4) @(negedge clk);
        $display("run covered %0d input beats, %0d result beats, %0d register writes",
                 tick_count, result_count, cfg_writes);
        $display("events seen: none %0d, up %0d, down %0d, short %0d, long %0d",
                 ev_seen[rkd_pkg::EV_NONE], ev_seen[rkd_pkg::EV_UP],
                 ev_seen[rkd_pkg::EV_DOWN], ev_seen[rkd_pkg::EV_SHORT],
                 ev_seen[rkd_pkg::EV_LONG]);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/rkd_pkg.sv
hdl/rkd_cfg_regs.sv
hdl/rkd_decode.sv
hdl/rkd_adjust.sv
hdl/rotary_knob_decoder_adjuster.sv
tb/rotary_knob_decoder_adjuster_tb.sv
